[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, codes and word types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         new_item;
    logic signed [15:0] new_priority;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       out_item;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

  typedef struct packed {
    logic [7:0]         item;
    logic signed [15:0] priority_v;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One storage slot that keeps, takes the new entry or shifts from a neighbour.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_lt_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       lt_o
);

  entry_t entry_q, entry_d;

  assign lt_o    = valid_i && ($signed(entry_q.priority_v) < $signed(new_i.priority_v));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!lt_o) begin
        entry_d = left_lt_i ? new_i : left_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[design/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by ascending signed priority in a row of cells.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge with start_i high and busy_o low.
// busy_o is always low, so a new word may be given in every cycle. An insert
// word places its byte before the first stored entry of equal or larger
// priority; a remove word returns and drops the head entry.
// The word is held in an input register; in the following cycle every cell
// compares itself against the new priority in parallel and shifts, and the
// result word is registered. It appears on res_o with done_o high for
// exactly one cycle, once it has gone through the input register and the
// result register. One word per cycle is sustained, set by the single
// compare-and-shift pass over the cells.
// The receiver cannot stall, so results must be taken as they appear.
// Reset empties the queue; stored bytes and priorities are not cleared.
// A remove from an empty queue reports empty, and an insert into a full
// queue is dropped and reports full.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  in_i,
  output logic      busy_o,
  output logic      done_o,
  output out_word_t res_o
);

  logic             in_vld_q;
  in_word_t         in_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  out_word_t        res_q, res_d;
  logic             full, empty;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           entries [DEPTH];
  logic             lt      [DEPTH];

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= in_i;
    end
  end

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.insert = in_vld_q && (in_q.opcode == OP_INSERT) && !full;
  assign ctrl.remove = in_vld_q && (in_q.opcode == OP_REMOVE) && !empty;

  assign new_entry.item       = in_q.new_item;
  assign new_entry.priority_v = in_q.new_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left, right;
    logic   left_lt;
    if (i == 0) begin : g_head
      assign left    = new_entry;
      assign left_lt = 1'b1;
    end else begin : g_body
      assign left    = entries[i-1];
      assign left_lt = lt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = entries[i];
    end else begin : g_inner
      assign right = entries[i+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (count_q > CNT_W'(i)),
      .new_i     (new_entry),
      .left_i    (left),
      .left_lt_i (left_lt),
      .right_i   (right),
      .entry_o   (entries[i]),
      .lt_o      (lt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - CNT_W'(1);
    end
    res_d.out_item  = ctrl.remove ? entries[0].item : 8'd0;
    res_d.status    = ST_DONE;
    if (in_q.opcode == OP_INSERT && full) begin
      res_d.status = ST_FULL;
    end else if (in_q.opcode == OP_REMOVE && empty) begin
      res_d.status = ST_EMPTY;
    end
    res_d.occupancy = OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(in_vld_q))
    else $error("Result strobe without a command word.");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("Remove did not drop one entry.");

  a_empty_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.status == ST_EMPTY |-> res_q.out_item == 8'd0 && count_q == '0)
    else $error("Empty status with a non-empty queue or a byte.");

  a_full_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.status == ST_FULL |-> count_q == CNT_W'(DEPTH))
    else $error("Full status while the queue has room.");

endmodule
